@@ design/ffbp_pkg.sv @@
// Shared types and constants of the first-fit bin packer.
// Depends on nothing; every other design file imports it.
`default_nettype none

package ffbp_pkg;

    localparam int SIZE_W = 17;
    localparam int BIN_W  = 6;
    localparam int ERR_W  = 2;

    localparam logic [SIZE_W-1:0] CAP_RESET = 17'h10000;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK       = 2'd0,
        ERR_OVERSIZE = 2'd1,
        ERR_NO_BIN   = 2'd2
    } err_code_t;

    typedef enum logic {
        KIND_ASSIGN = 1'b0,
        KIND_REPORT = 1'b1
    } result_kind_t;

    // Broadcast command to every cell of the bin row.
    typedef struct packed {
        logic              place;
        logic              shift;
        logic [SIZE_W-1:0] size;
        logic [SIZE_W-1:0] cap;
    } cell_cmd_t;

    // What one cell shows to its neighbors and to the controller.
    typedef struct packed {
        logic              open;
        logic              take;
        logic              claim;
        logic [SIZE_W-1:0] room;
    } cell_stat_t;

endpackage

`default_nettype wire

@@ design/ffbp_ifs.sv @@
// Valid/ready channel interfaces of the first-fit bin packer.
// Depends on ffbp_pkg for field widths.
`default_nettype none

interface ffbp_in_if;
    logic                       valid;
    logic                       ready;
    logic [ffbp_pkg::SIZE_W-1:0] item_size;
    logic                       last_item;

    modport source (output valid, output item_size, output last_item, input ready);
    modport sink   (input valid, input item_size, input last_item, output ready);
endinterface

interface ffbp_out_if;
    logic                        valid;
    logic                        ready;
    logic                        result_kind;
    logic [ffbp_pkg::BIN_W-1:0]  bin_number;
    logic [ffbp_pkg::SIZE_W-1:0] free_room;
    logic [ffbp_pkg::ERR_W-1:0]  error_code;
    logic                        last_result;

    modport source (output valid, output result_kind, output bin_number,
                    output free_room, output error_code, output last_result,
                    input ready);
    modport sink   (input valid, input result_kind, input bin_number,
                    input free_room, input error_code, input last_result,
                    output ready);
endinterface

`default_nettype wire

@@ design/ffbp_cell.sv @@
// One bin of the packer row: holds its open flag and remaining room.
// Depends on ffbp_pkg; instantiated in a chain by first_fit_bin_packer.
`default_nettype none

module ffbp_cell (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire ffbp_pkg::cell_cmd_t   cmd,
    input  wire logic                  claim_in,
    input  wire logic                  prev_open,
    input  wire logic                  next_open,
    input  wire logic [ffbp_pkg::SIZE_W-1:0] next_room,
    output ffbp_pkg::cell_stat_t       stat
);
    import ffbp_pkg::*;

    logic              open_reg;
    logic              open_next;
    logic [SIZE_W-1:0] room_reg;
    logic [SIZE_W-1:0] room_next;
    logic              fit;
    logic              opening;
    logic              take;

    // Fit in an open bin, or open this bin if it is the first closed one.
    assign fit     = open_reg && (room_reg >= cmd.size);
    assign opening = !open_reg && prev_open;
    assign take    = cmd.place && !claim_in && (fit || opening);

    always_comb
    begin
        open_next = open_reg;
        room_next = room_reg;
        if (cmd.shift)
        begin
            // advance the row one place toward cell zero
            open_next = next_open;
            room_next = next_room;
        end
        else if (take)
        begin
            open_next = 1'b1;
            room_next = fit ? (room_reg - cmd.size) : (cmd.cap - cmd.size);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 1'b0;
        end
        else
        begin
            open_reg <= open_next;
        end
    end

    always_ff @(posedge clk)
    begin
        room_reg <= room_next;
    end

    assign stat.open  = open_reg;
    assign stat.take  = take;
    assign stat.claim = claim_in || take;
    assign stat.room  = room_reg;

endmodule

`default_nettype wire

@@ design/first_fit_bin_packer.sv @@
// Top level of the first-fit bin packer: controller, capacity register, bin row.
// Depends on ffbp_pkg, ffbp_ifs (ffbp_in_if, ffbp_out_if) and ffbp_cell.
//
//   channel   | dir | handshake          | payload
//   ----------+-----+--------------------+----------------------------------------
//   items     | in  | valid / ready      | item_size, last_item
//   results   | out | valid / ready      | result_kind, bin_number, free_room,
//             |     |                    | error_code, last_result
//   cfg       | in  | cfg_we, no ready   | cfg_wdata -> bin_capacity
//
// An item is accepted in the idle step; in the place step all cells compare
// in parallel, the claim ripple picks the lowest fitting bin and the result word loads.
// A batch-closing item then adds a report step per open bin: the row shifts toward cell
// zero and reports bin 1 first, which also empties the row for the next batch.
// A stalled result word holds the controller in place; at most one more item is
// taken meanwhile and it waits in the place step until the result word moves.
// Reset closes every bin and loads the capacity with 1.0; no clearing pass is needed.
`default_nettype none

module first_fit_bin_packer #(
    parameter int MAX_BINS = 63
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [ffbp_pkg::SIZE_W-1:0] cfg_wdata,
    ffbp_in_if.sink                          items,
    ffbp_out_if.source                       results
);
    import ffbp_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PLACE,
        S_REPORT
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [SIZE_W-1:0] cap_reg;
    logic [SIZE_W-1:0] size_reg;
    logic              batch_end_reg;
    logic [BIN_W-1:0]  rpt_cnt_reg;
    logic [BIN_W-1:0]  rpt_cnt_next;

    // registered result word
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_kind_reg;
    logic              out_kind_next;
    logic [BIN_W-1:0]  out_bin_reg;
    logic [BIN_W-1:0]  out_bin_next;
    logic [SIZE_W-1:0] out_room_reg;
    logic [SIZE_W-1:0] out_room_next;
    logic [ERR_W-1:0]  out_err_reg;
    logic [ERR_W-1:0]  out_err_next;
    logic              out_last_reg;
    logic              out_last_next;

    cell_cmd_t         cmd;
    cell_stat_t        stat [MAX_BINS];
    logic              claim [MAX_BINS+1];
    logic              out_free;
    logic              oversize;
    logic              placed;
    logic              second_open;
    logic [BIN_W-1:0]  take_bin;
    logic              accept;

    assign accept   = items.valid && items.ready;
    assign out_free = !out_valid_reg || results.ready;
    assign oversize = size_reg > cap_reg;

    assign cmd.place = (state_reg == S_PLACE) && out_free && !oversize;
    assign cmd.shift = (state_reg == S_REPORT) && out_free;
    assign cmd.size  = size_reg;
    assign cmd.cap   = cap_reg;

    // Row of bins; the claim flag ripples from bin 1 upward.
    assign claim[0] = 1'b0;

    for (genvar i = 0; i < MAX_BINS; i++)
    begin : g_cell
        logic              prev_open;
        logic              nb_open;
        logic [SIZE_W-1:0] nb_room;

        if (i == 0)
        begin : g_first
            assign prev_open = 1'b1;
        end
        else
        begin : g_mid
            assign prev_open = stat[i-1].open;
        end

        if (i == MAX_BINS - 1)
        begin : g_end
            assign nb_open = 1'b0;
            assign nb_room = '0;
        end
        else
        begin : g_inner
            assign nb_open = stat[i+1].open;
            assign nb_room = stat[i+1].room;
        end

        ffbp_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .claim_in  (claim[i]),
            .prev_open (prev_open),
            .next_open (nb_open),
            .next_room (nb_room),
            .stat      (stat[i])
        );

        assign claim[i+1] = stat[i].claim;
    end

    assign placed = claim[MAX_BINS];

    if (MAX_BINS > 1)
    begin : g_two
        assign second_open = stat[1].open;
    end
    else
    begin : g_one
        assign second_open = 1'b0;
    end

    // At most one cell takes the item; OR together its number.
    always_comb
    begin
        take_bin = '0;
        for (int i = 0; i < MAX_BINS; i++)
        begin
            if (stat[i].take)
            begin
                take_bin = take_bin | BIN_W'(i + 1);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        rpt_cnt_next   = rpt_cnt_reg;
        out_valid_next = out_valid_reg && !results.ready;
        out_kind_next  = out_kind_reg;
        out_bin_next   = out_bin_reg;
        out_room_next  = out_room_reg;
        out_err_next   = out_err_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_ASSIGN;
                    out_room_next  = '0;
                    out_bin_next   = placed ? take_bin : '0;
                    if (oversize)
                    begin
                        out_err_next = ERR_OVERSIZE;
                    end
                    else if (placed)
                    begin
                        out_err_next = ERR_OK;
                    end
                    else
                    begin
                        out_err_next = ERR_NO_BIN;
                    end
                    // the assignment closes the input unless bins follow
                    out_last_next = !batch_end_reg || (!stat[0].open && !placed);
                    rpt_cnt_next  = BIN_W'(1);
                    if (batch_end_reg && (stat[0].open || placed))
                    begin
                        state_next = S_REPORT;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_REPORT:
            begin
                if (out_free)
                begin
                    // report bin at cell zero, then shift the row down
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_REPORT;
                    out_bin_next   = rpt_cnt_reg;
                    out_room_next  = stat[0].room;
                    out_err_next   = ERR_OK;
                    out_last_next  = !second_open;
                    rpt_cnt_next   = rpt_cnt_reg + BIN_W'(1);
                    if (!second_open)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            out_kind_reg  <= KIND_ASSIGN;
            out_bin_reg   <= '0;
            out_room_reg  <= '0;
            out_err_reg   <= ERR_OK;
            out_last_reg  <= 1'b0;
            cap_reg       <= CAP_RESET;
            rpt_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            out_kind_reg  <= out_kind_next;
            out_bin_reg   <= out_bin_next;
            out_room_reg  <= out_room_next;
            out_err_reg   <= out_err_next;
            out_last_reg  <= out_last_next;
            rpt_cnt_reg   <= rpt_cnt_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            size_reg      <= items.item_size;
            batch_end_reg <= items.last_item;
        end
    end

    assign items.ready         = (state_reg == S_IDLE);
    assign results.valid       = out_valid_reg;
    assign results.result_kind = out_kind_reg;
    assign results.bin_number  = out_bin_reg;
    assign results.free_room   = out_room_reg;
    assign results.error_code  = out_err_reg;
    assign results.last_result = out_last_reg;

endmodule

`default_nettype wire

@@ design/ffbp_checker.sv @@
// Port-level checker of the first-fit bin packer, bound to its top level.
// Depends on ffbp_pkg and first_fit_bin_packer.
`default_nettype none

module ffbp_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        out_valid,
    input wire logic                        out_ready,
    input wire logic                        out_kind,
    input wire logic [ffbp_pkg::BIN_W-1:0]  out_bin,
    input wire logic [ffbp_pkg::SIZE_W-1:0] out_room,
    input wire logic [ffbp_pkg::ERR_W-1:0]  out_err,
    input wire logic                        out_last
);
    import ffbp_pkg::*;

    // hold a stalled result word
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_bin) && $stable(out_room)
            && $stable(out_kind) && $stable(out_err) && $stable(out_last))
        else $error("result payload changed while stalled");

    a_report_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_kind == KIND_REPORT) |-> (out_err == ERR_OK) && (out_bin != '0))
        else $error("free-space report with error or no bin");

    a_assign_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_kind == KIND_ASSIGN)
            |-> (out_room == '0) && ((out_err == ERR_OK) == (out_bin != '0)))
        else $error("assignment bin number disagrees with error code");

    // a word that does not close the batch is followed by a report, of the next bin if it was a report
    a_report_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_last ##1 out_valid
            |-> (out_kind == KIND_REPORT)
                && (out_bin == $past(out_bin) + BIN_W'(1) || $past(out_kind) == KIND_ASSIGN))
        else $error("reports out of order");

endmodule

bind first_fit_bin_packer ffbp_checker u_ffbp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_kind  (results.result_kind),
    .out_bin   (results.bin_number),
    .out_room  (results.free_room),
    .out_err   (results.error_code),
    .out_last  (results.last_result)
);

`default_nettype wire
